// File: sv/matrix_multiply_accumulate_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply-accumulate block
// Concurrent checks with synchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH

`ifndef ASSERT_OFF
// cond must never be true at a clock edge
`define MMA_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("mma assertion failed");
// when ante holds, cons must hold in the same cycle
`define MMA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mma assertion failed");
`else
`define MMA_ASSERT_NEVER(label, clk, rst_n, cond)
`define MMA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Types, codes and microcode table of the matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int MAX_DIM_DEF = 64;

  localparam int KIND_W    = 3;
  localparam int POS_W     = 6;
  localparam int ELEM_W    = 16;
  localparam int ACC_W     = 48;
  localparam int STATUS_W  = 2;
  localparam int SIZE_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 2 * ELEM_W;
  // old C plus at most 64 products of magnitude 2^30 fits in 49 bits
  localparam int SUM_W     = ACC_W + 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  localparam logic [KIND_W-1:0] KIND_WRITE_A = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE_B = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE_C = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RUN     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_C  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_N  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_K = 2'd2;

  localparam logic [ACC_W-1:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0] ACC_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic signed [ELEM_W-1:0] elem_value;
    logic signed [ACC_W-1:0]  acc_value;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] read_value;
    logic [STATUS_W-1:0]     status;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;
  } cfg_item_t;

  // sequencer steps
  typedef enum logic [3:0] {
    U_IDLE,
    U_RUN_INIT,
    U_CELL,
    U_DOT,
    U_DRAIN1,
    U_DRAIN2,
    U_STORE,
    U_RUN_EMIT,
    U_READ_EMIT
  } step_t;

  typedef enum logic [2:0] {
    JMP_GOTO,      // unconditional to target
    JMP_DISPATCH,  // branch on the kind of the accepted transaction
    JMP_DOT,       // repeat until the last inner index, then target
    JMP_CELL,      // back to U_CELL until the last C entry, then target
    JMP_OUT        // hold until the output register is free, then target
  } jump_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_READ,
    EMIT_RUN
  } emit_t;

  typedef struct packed {
    logic  accept;
    logic  run_init;
    logic  cell_start;
    logic  dot_issue;
    logic  store;
    emit_t emit;
    jump_t jump;
    step_t target;
  } ucw_t;

  function automatic ucw_t ucode_rom(input step_t step);
    ucw_t w;
    w        = '0;
    w.emit   = EMIT_NONE;
    w.jump   = JMP_GOTO;
    w.target = U_IDLE;
    case (step)
      U_IDLE: begin
        w.accept = 1'b1;
        w.jump   = JMP_DISPATCH;
        w.target = U_IDLE;
      end
      U_RUN_INIT: begin
        w.run_init = 1'b1;
        w.target   = U_CELL;
      end
      U_CELL: begin
        w.cell_start = 1'b1;
        w.target     = U_DOT;
      end
      U_DOT: begin
        w.dot_issue = 1'b1;
        w.jump      = JMP_DOT;
        w.target    = U_DRAIN1;
      end
      U_DRAIN1: w.target = U_DRAIN2;
      U_DRAIN2: w.target = U_STORE;
      U_STORE: begin
        w.store  = 1'b1;
        w.jump   = JMP_CELL;
        w.target = U_RUN_EMIT;
      end
      U_RUN_EMIT: begin
        w.emit   = EMIT_RUN;
        w.jump   = JMP_OUT;
        w.target = U_IDLE;
      end
      U_READ_EMIT: begin
        w.emit   = EMIT_READ;
        w.jump   = JMP_OUT;
        w.target = U_IDLE;
      end
      default: begin
        w.jump   = JMP_GOTO;
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: sv/mma_chan_if.sv
// ----------------------------------------------------------------------------
// mma_chan_if
// Valid/ready channel carrying one payload struct per transaction.
// ----------------------------------------------------------------------------
interface mma_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: sv/matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// Fixed-point C = C + A * B over on-chip A, B and C stores, run by a
// microcoded sequencer over a single multiply-accumulate datapath.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                     accepted when
//  in_chan   in   kind, row, col, elem_value, acc_value       valid && ready
//  out_chan  out  read_value, status                          valid && ready
//  cfg_chan  in   index (rows_m, cols_n, inner_k), data       valid && ready
//
//  Write A/B/C and unknown kinds: result registered.
//  Read C: C memory read port, then output register.
//  Run: one A/B read pair per cycle in the inner loop, plus per entry a C fetch,
//  multiply/accumulate drain (U_DRAIN1, U_DRAIN2) and write-back.
//  Reset is synchronous; size registers reset to 64, stores are not cleared.
//  in_chan stalls while a run or read is in progress or a result cannot move on.
// ----------------------------------------------------------------------------
`include "matrix_multiply_accumulate_macros.svh"

module matrix_multiply_accumulate #(
  parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mma_chan_if.sink   in_chan,
  mma_chan_if.source out_chan,
  mma_chan_if.sink   cfg_chan
);

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SZ_W   = ($clog2(MAX_DIM + 1) > mma_pkg::SIZE_W) ?
                          $clog2(MAX_DIM + 1) : mma_pkg::SIZE_W;
  localparam int CMP_W  = (IDX_W > mma_pkg::POS_W) ? IDX_W : mma_pkg::POS_W;

  localparam int ACC_W  = mma_pkg::ACC_W;
  localparam int SUM_W  = mma_pkg::SUM_W;
  localparam int PROD_W = mma_pkg::PROD_W;
  localparam int ELEM_W = mma_pkg::ELEM_W;

  // size register to last usable index: 0 acts as 1, oversize clamps
  function automatic logic [IDX_W-1:0] last_of(input logic [mma_pkg::SIZE_W-1:0] r);
    logic [SZ_W-1:0] rx;
    rx = SZ_W'(r);
    if (rx == '0) return '0;
    else if (rx > SZ_W'(MAX_DIM)) return IDX_W'(MAX_DIM - 1);
    else return IDX_W'(rx - SZ_W'(1));
  endfunction

  function automatic logic in_range(input logic [mma_pkg::POS_W-1:0] pos,
                                    input logic [IDX_W-1:0] last);
    return CMP_W'(pos) <= CMP_W'(last);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

  // ---------------------------------------------------------------- config
  logic [mma_pkg::SIZE_W-1:0] rows_m_r, cols_n_r, inner_k_r;
  logic [IDX_W-1:0]           m_last, n_last, k_last;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_m_r  <= mma_pkg::SIZE_RESET;
      cols_n_r  <= mma_pkg::SIZE_RESET;
      inner_k_r <= mma_pkg::SIZE_RESET;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.data.index)
        mma_pkg::CFG_ROWS_M:  rows_m_r  <= cfg_chan.data.data;
        mma_pkg::CFG_COLS_N:  cols_n_r  <= cfg_chan.data.data;
        mma_pkg::CFG_INNER_K: inner_k_r <= cfg_chan.data.data;
        default: ;
      endcase
    end
  end

  assign m_last = last_of(rows_m_r);
  assign n_last = last_of(cols_n_r);
  assign k_last = last_of(inner_k_r);

  // ------------------------------------------------------------- sequencer
  mma_pkg::step_t upc_r, upc_nxt;
  mma_pkg::ucw_t  ctl;

  logic in_acc, out_free, last_cell;
  logic [mma_pkg::KIND_W-1:0] kind;
  logic a_ok, b_ok, c_ok;

  logic [IDX_W-1:0] i_r, j_r, l_r, i_nxt, j_nxt, l_nxt;

  logic                 out_valid_r;
  mma_pkg::out_item_t   out_data_r, out_data_nxt;

  always_comb begin
    ctl = mma_pkg::ucode_rom(upc_r);
  end

  assign kind      = in_chan.data.kind;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign in_chan.ready = ctl.accept && out_free;
  assign in_acc    = in_chan.valid && in_chan.ready;
  assign last_cell = (i_r == m_last) && (j_r == n_last);

  assign a_ok = in_range(in_chan.data.row, m_last) && in_range(in_chan.data.col, k_last);
  assign b_ok = in_range(in_chan.data.row, k_last) && in_range(in_chan.data.col, n_last);
  assign c_ok = in_range(in_chan.data.row, m_last) && in_range(in_chan.data.col, n_last);

  always_comb begin
    upc_nxt = upc_r;
    case (ctl.jump)
      mma_pkg::JMP_GOTO: upc_nxt = ctl.target;
      mma_pkg::JMP_DISPATCH: begin
        if (in_acc) begin
          if (kind == mma_pkg::KIND_RUN) upc_nxt = mma_pkg::U_RUN_INIT;
          else if (kind == mma_pkg::KIND_READ_C) upc_nxt = mma_pkg::U_READ_EMIT;
          else upc_nxt = ctl.target;
        end
      end
      mma_pkg::JMP_DOT:  if (l_r == k_last) upc_nxt = ctl.target;
      mma_pkg::JMP_CELL: upc_nxt = last_cell ? ctl.target : mma_pkg::U_CELL;
      mma_pkg::JMP_OUT:  if (out_free) upc_nxt = ctl.target;
      default: upc_nxt = mma_pkg::U_IDLE;
    endcase
  end

  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    l_nxt = l_r;
    if (ctl.run_init) begin
      i_nxt = '0;
      j_nxt = '0;
    end
    if (ctl.cell_start) l_nxt = '0;
    if (ctl.dot_issue) l_nxt = l_r + 1'b1;
    if (ctl.store) begin
      if (j_r == n_last) begin
        j_nxt = '0;
        i_nxt = i_r + 1'b1;
      end else begin
        j_nxt = j_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= mma_pkg::U_IDLE;
      i_r   <= '0;
      j_r   <= '0;
      l_r   <= '0;
    end else begin
      upc_r <= upc_nxt;
      i_r   <= i_nxt;
      j_r   <= j_nxt;
      l_r   <= l_nxt;
    end
  end

  // -------------------------------------------------------------- memories
  logic [ELEM_W-1:0] a_mem [DEPTH];
  logic [ELEM_W-1:0] b_mem [DEPTH];
  logic [ACC_W-1:0]  c_mem [DEPTH];

  logic [ADDR_W-1:0] in_addr, cell_addr, a_rd_addr, b_rd_addr, c_rd_addr, c_wr_addr;
  logic              a_we, b_we, c_we, c_rd_en;
  logic [ACC_W-1:0]  c_wr_data, sat_value;

  logic signed [ELEM_W-1:0] a_rd_r, b_rd_r;
  logic [ACC_W-1:0]         c_rd_r;

  assign in_addr   = addr_of(IDX_W'(in_chan.data.row), IDX_W'(in_chan.data.col));
  assign cell_addr = addr_of(i_r, j_r);
  assign a_rd_addr = addr_of(i_r, l_r);
  assign b_rd_addr = addr_of(l_r, j_r);

  assign a_we      = in_acc && (kind == mma_pkg::KIND_WRITE_A) && a_ok;
  assign b_we      = in_acc && (kind == mma_pkg::KIND_WRITE_B) && b_ok;
  assign c_we      = (in_acc && (kind == mma_pkg::KIND_WRITE_C) && c_ok) || ctl.store;
  assign c_wr_addr = ctl.store ? cell_addr : in_addr;
  assign c_wr_data = ctl.store ? sat_value : in_chan.data.acc_value;
  assign c_rd_en   = (in_acc && (kind == mma_pkg::KIND_READ_C)) || ctl.cell_start;
  assign c_rd_addr = ctl.cell_start ? cell_addr : in_addr;

  always_ff @(posedge clk) begin
    if (a_we) a_mem[in_addr] <= in_chan.data.elem_value;
    a_rd_r <= a_mem[a_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) b_mem[in_addr] <= in_chan.data.elem_value;
    b_rd_r <= b_mem[b_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (c_we) c_mem[c_wr_addr] <= c_wr_data;
    if (c_rd_en) c_rd_r <= c_mem[c_rd_addr];
  end

  // ------------------------------------------------------ multiply / accum
  logic                     cread_v_r, rd_v_r, prod_v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]         acc_r;
  logic                     over, under;
  logic                     sat_r, rd_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cread_v_r <= 1'b0;
      rd_v_r    <= 1'b0;
      prod_v_r  <= 1'b0;
    end else begin
      cread_v_r <= ctl.cell_start;
      rd_v_r    <= ctl.dot_issue;
      prod_v_r  <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_rd_r * b_rd_r;
    // old C arrives in the cycle after the fetch, well ahead of the first product
    if (cread_v_r)
      acc_r <= {{(SUM_W - ACC_W){c_rd_r[ACC_W-1]}}, c_rd_r};
    else if (prod_v_r)
      acc_r <= acc_r + {{(SUM_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
  end

  assign over      = !acc_r[SUM_W-1] && acc_r[ACC_W-1];
  assign under     = acc_r[SUM_W-1] && !acc_r[ACC_W-1];
  assign sat_value = over ? mma_pkg::ACC_MAX : (under ? mma_pkg::ACC_MIN : acc_r[ACC_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r      <= 1'b0;
      rd_range_r <= 1'b0;
    end else begin
      if (ctl.run_init) sat_r <= 1'b0;
      else if (ctl.store && (over || under)) sat_r <= 1'b1;
      if (in_acc && (kind == mma_pkg::KIND_READ_C)) rd_range_r <= !c_ok;
    end
  end

  // ---------------------------------------------------------------- output
  logic load_emit, emit_fire;

  assign load_emit = in_acc && (kind != mma_pkg::KIND_RUN) && (kind != mma_pkg::KIND_READ_C);
  assign emit_fire = (ctl.emit != mma_pkg::EMIT_NONE) && out_free;

  always_comb begin
    out_data_nxt.read_value = '0;
    out_data_nxt.status     = mma_pkg::ST_OK;
    if (ctl.emit == mma_pkg::EMIT_READ) begin
      out_data_nxt.read_value = rd_range_r ? '0 : c_rd_r;
      out_data_nxt.status     = rd_range_r ? mma_pkg::ST_RANGE : mma_pkg::ST_OK;
    end else if (ctl.emit == mma_pkg::EMIT_RUN) begin
      out_data_nxt.status = sat_r ? mma_pkg::ST_SAT : mma_pkg::ST_OK;
    end else begin
      case (kind)
        mma_pkg::KIND_WRITE_A: if (!a_ok) out_data_nxt.status = mma_pkg::ST_RANGE;
        mma_pkg::KIND_WRITE_B: if (!b_ok) out_data_nxt.status = mma_pkg::ST_RANGE;
        mma_pkg::KIND_WRITE_C: if (!c_ok) out_data_nxt.status = mma_pkg::ST_RANGE;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_emit || emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_emit || emit_fire) out_data_r <= out_data_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // ------------------------------------------------------------ assertions
  // accumulator load and product add never collide
  `MMA_ASSERT_NEVER(a_acc_collide, clk, rst_n, cread_v_r && prod_v_r)
  // write-back only after the multiply pipeline has drained
  `MMA_ASSERT_IMPLY(a_store_drained, clk, rst_n, ctl.store, !rd_v_r && !prod_v_r)
  // a transaction is taken only when its result has a free slot
  `MMA_ASSERT_IMPLY(a_accept_slot, clk, rst_n, in_acc, !out_valid_r || out_chan.ready)
  // a read always finds the output register empty
  `MMA_ASSERT_IMPLY(a_read_slot, clk, rst_n, upc_r == mma_pkg::U_READ_EMIT, !out_valid_r)

endmodule

// File: test/matrix_multiply_accumulate_tb.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_tb
// Self-checking bench for the fixed-point multiply-accumulate block. A short
// table of directed transactions covers extremes, range errors, unknown kinds
// and saturation in both directions. Random phases follow: each phase sets new
// sizes, loads each unwritten element a run will use, then mixes loads, reads,
// runs and out-of-range accesses. Results are checked field by field against
// a behavioral predictor of the stores and the saturating dot-product sums.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_tb;
  import mma_pkg::*;

  localparam int DIM             = MAX_DIM_DEF;
  localparam int RANDOM_ITEMS    = 550;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int DRAIN_CYCLES    = 16;

  localparam logic [KIND_W-1:0]    KIND_SPARE_LO = KIND_READ_C + 3'd1;
  localparam logic [KIND_W-1:0]    KIND_SPARE_HI = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = '1;

  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 64'sd1;

  typedef struct {
    bit        is_cfg;
    cfg_item_t cfg;
    in_item_t  op;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  mma_chan_if #(.payload_t(in_item_t))  in_chan ();
  mma_chan_if #(.payload_t(out_item_t)) out_chan ();
  mma_chan_if #(.payload_t(cfg_item_t)) cfg_chan ();

  matrix_multiply_accumulate u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // predictor state
  logic signed [ELEM_W-1:0] a_mem [DIM*DIM];
  logic signed [ELEM_W-1:0] b_mem [DIM*DIM];
  logic signed [ACC_W-1:0]  c_mem [DIM*DIM];
  bit                       a_set [DIM*DIM];
  bit                       b_set [DIM*DIM];
  bit                       c_set [DIM*DIM];
  logic [SIZE_W-1:0]        rows_reg  = SIZE_RESET;
  logic [SIZE_W-1:0]        cols_reg  = SIZE_RESET;
  logic [SIZE_W-1:0]        inner_reg = SIZE_RESET;

  out_item_t result_q [$];
  out_item_t want_res;
  dir_row_t  dir_q [$];
  int        err_count;
  int        idle_cycles;
  int        hold_left;
  bit        no_idle;
  bit        out_take;

  function automatic int eff_dim(logic [SIZE_W-1:0] r);
    if (r == '0) return 1;
    if (r > DIM) return DIM;
    return int'(r);
  endfunction

  function automatic out_item_t mac_predict(in_item_t op);
    int        m, n, k, idx, ci, i, j, l;
    longint    sum;
    out_item_t res;
    m   = eff_dim(rows_reg);
    n   = eff_dim(cols_reg);
    k   = eff_dim(inner_reg);
    idx = op.row * DIM + op.col;
    res = '0;
    res.status = ST_OK;
    case (op.kind)
      KIND_WRITE_A: begin
        if (op.row < m && op.col < k) begin
          a_mem[idx] = op.elem_value;
          a_set[idx] = 1'b1;
        end else res.status = ST_RANGE;
      end
      KIND_WRITE_B: begin
        if (op.row < k && op.col < n) begin
          b_mem[idx] = op.elem_value;
          b_set[idx] = 1'b1;
        end else res.status = ST_RANGE;
      end
      KIND_WRITE_C: begin
        if (op.row < m && op.col < n) begin
          c_mem[idx] = op.acc_value;
          c_set[idx] = 1'b1;
        end else res.status = ST_RANGE;
      end
      KIND_RUN: begin
        for (i = 0; i < m; i++) begin
          for (j = 0; j < n; j++) begin
            ci  = i * DIM + j;
            sum = c_mem[ci];
            for (l = 0; l < k; l++)
              sum += longint'(a_mem[i*DIM+l]) * longint'(b_mem[l*DIM+j]);
            // one saturation per entry, after the exact sum
            if (sum > SUM_HI) begin
              sum = SUM_HI;
              res.status = ST_SAT;
            end else if (sum < SUM_LO) begin
              sum = SUM_LO;
              res.status = ST_SAT;
            end
            c_mem[ci] = sum[ACC_W-1:0];
          end
        end
      end
      KIND_READ_C: begin
        if (op.row < m && op.col < n) res.read_value = c_mem[idx];
        else res.status = ST_RANGE;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic dir_row_t op_row(logic [KIND_W-1:0] kind, int row, int col,
                                      logic [ELEM_W-1:0] elem, logic [ACC_W-1:0] acc,
                                      bit typed = 1'b0, logic [ACC_W-1:0] want_val = '0,
                                      logic [STATUS_W-1:0] want_st = ST_OK);
    dir_row_t d;
    d = '{default: '0};
    d.op.kind            = kind;
    d.op.row             = POS_W'(row);
    d.op.col             = POS_W'(col);
    d.op.elem_value      = elem;
    d.op.acc_value       = acc;
    d.typed              = typed;
    d.want.read_value    = want_val;
    d.want.status        = want_st;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] index, logic [SIZE_W-1:0] data);
    dir_row_t d;
    d = '{default: '0};
    d.is_cfg     = 1'b1;
    d.cfg.index  = index;
    d.cfg.data   = data;
    return d;
  endfunction

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return '0;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [ACC_W-1:0] rand_acc();
    case ($urandom_range(0, 7))
      0:       return ACC_MAX - ACC_W'($urandom);
      1:       return ACC_MIN + ACC_W'($urandom);
      2:       return ACC_W'(int'($urandom) >>> 8);
      default: return ACC_W'({$urandom, $urandom});
    endcase
  endfunction

  // mostly inside the configured bound, sometimes anywhere
  function automatic logic [POS_W-1:0] pick_pos(int lim);
    if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, lim - 1));
    return POS_W'($urandom_range(0, DIM - 1));
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    $display("mismatch %s: got %h, expected %h", what, got, exp_val);
    err_count++;
  endtask

  task automatic send_op(in_item_t op, bit typed, out_item_t want);
    int        gap;
    out_item_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= op;
    @(negedge clk);
    while (!in_chan.ready) @(negedge clk);
    // transaction happens at the coming edge
    pred = mac_predict(op);
    result_q.push_back(typed ? want : pred);
    @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] index, logic [SIZE_W-1:0] data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      cfg_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_chan.valid      <= 1'b1;
    cfg_chan.data.index <= index;
    cfg_chan.data.data  <= data;
    @(negedge clk);
    while (!cfg_chan.ready) @(negedge clk);
    case (index)
      CFG_ROWS_M:  rows_reg  = data;
      CFG_COLS_N:  cols_reg  = data;
      CFG_INNER_K: inner_reg = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // block idle: input held off and every result collected
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // result checking, sampled mid-cycle
  always @(negedge clk) begin
    out_take = rst_n && out_chan.valid && out_chan.ready;
    if (out_take) begin
      if (result_q.size() == 0) begin
        report_mismatch("result with no transaction pending", 64'(out_chan.data), '0);
      end else begin
        want_res = result_q.pop_front();
        if (out_chan.data.read_value !== want_res.read_value)
          report_mismatch("read_value", 64'(out_chan.data.read_value),
                          64'(want_res.read_value));
        if (out_chan.data.status !== want_res.status)
          report_mismatch("status", 64'(out_chan.data.status), 64'(want_res.status));
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_left = 0;
    end else if (out_take || !out_chan.ready) begin
      if (out_take) hold_left = no_idle ? 0 : $urandom_range(0, 7);
      else if (hold_left > 0) hold_left--;
      out_chan.ready <= (hold_left == 0);
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
        || (cfg_chan.valid && cfg_chan.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("matrix_multiply_accumulate verification failed");
      $finish;
    end
  end

  initial begin
    in_item_t          it;
    int                items_sent, body_len, r, m, n, k, i, j, pick;
    logic [SIZE_W-1:0] raw [3];
    bit                cfg_open;

    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data  = '0;
    out_chan.ready = 1'b0;
    err_count      = 0;
    no_idle        = 1'b0;
    cfg_open       = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, sizes at reset value first
    dir_q.push_back(op_row(KIND_WRITE_A, 0, 0, 16'h7FFF, '0, 1'b1));
    dir_q.push_back(op_row(KIND_WRITE_A, 63, 63, 16'h8000, '0, 1'b1));
    dir_q.push_back(op_row(KIND_WRITE_B, 63, 63, 16'h7FFF, '0, 1'b1));
    dir_q.push_back(op_row(KIND_WRITE_C, 63, 63, '0, ACC_MAX, 1'b1));
    dir_q.push_back(op_row(KIND_READ_C, 63, 63, '0, '0, 1'b1, ACC_MAX));
    dir_q.push_back(op_row(KIND_WRITE_C, 0, 0, '1, ACC_MIN, 1'b1));
    dir_q.push_back(op_row(KIND_READ_C, 0, 0, '0, '0, 1'b1, ACC_MIN));
    dir_q.push_back(op_row(KIND_SPARE_LO, 63, 63, '1, '1, 1'b1));
    dir_q.push_back(op_row(KIND_SPARE_LO + 3'd1, 1, 2, '1, '1, 1'b1));
    dir_q.push_back(op_row(KIND_SPARE_HI, 63, 0, '1, '1, 1'b1));
    dir_q.push_back(cfg_row(CFG_ROWS_M, 7'd1));
    dir_q.push_back(cfg_row(CFG_COLS_N, 7'd1));
    dir_q.push_back(cfg_row(CFG_INNER_K, 7'd1));
    dir_q.push_back(cfg_row(CFG_SPARE, 7'h55));
    dir_q.push_back(op_row(KIND_WRITE_A, 0, 1, 16'h0100, '0, 1'b1, '0, ST_RANGE));
    dir_q.push_back(op_row(KIND_WRITE_B, 1, 0, 16'h0100, '0, 1'b1, '0, ST_RANGE));
    dir_q.push_back(op_row(KIND_WRITE_C, 0, 1, '0, 48'h1, 1'b1, '0, ST_RANGE));
    dir_q.push_back(op_row(KIND_READ_C, 1, 0, '0, '0, 1'b1, '0, ST_RANGE));
    dir_q.push_back(op_row(KIND_WRITE_B, 0, 0, 16'h7FFF, '0, 1'b1));
    dir_q.push_back(op_row(KIND_WRITE_C, 0, 0, '0, ACC_MAX, 1'b1));
    // positive overflow of the largest entry
    dir_q.push_back(op_row(KIND_RUN, 0, 0, '0, '0, 1'b1, '0, ST_SAT));
    dir_q.push_back(op_row(KIND_READ_C, 0, 0, '0, '0, 1'b1, ACC_MAX));
    dir_q.push_back(op_row(KIND_WRITE_C, 0, 0, '0, ACC_MIN, 1'b1));
    dir_q.push_back(op_row(KIND_WRITE_B, 0, 0, 16'h8000, '0, 1'b1));
    // negative overflow of the smallest entry
    dir_q.push_back(op_row(KIND_RUN, 0, 0, '0, '0, 1'b1, '0, ST_SAT));
    dir_q.push_back(op_row(KIND_READ_C, 0, 0, '0, '0, 1'b1, ACC_MIN));
    dir_q.push_back(op_row(KIND_WRITE_C, 0, 0, '0, 48'h1_0000));
    dir_q.push_back(op_row(KIND_RUN, 0, 0, '0, '0));
    dir_q.push_back(op_row(KIND_READ_C, 0, 0, '0, '0));

    foreach (dir_q[d]) begin
      if (dir_q[d].is_cfg) begin
        if (!cfg_open) settle();
        cfg_write(dir_q[d].cfg.index, dir_q[d].cfg.data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_chan.valid <= 1'b0;
        cfg_open = 1'b0;
        send_op(dir_q[d].op, dir_q[d].typed, dir_q[d].want);
      end
    end

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      // one dimension at the top of its range at a time keeps runs short
      pick = $urandom_range(0, 5);
      for (i = 0; i < 3; i++) begin
        if (i == pick) begin
          case ($urandom_range(0, 2))
            0:       raw[i] = SIZE_W'(DIM);
            1:       raw[i] = '1;
            default: raw[i] = SIZE_W'($urandom_range(DIM + 1, 127));
          endcase
        end else begin
          raw[i] = SIZE_W'($urandom_range(0, (pick < 3) ? 2 : 6));
        end
      end
      settle();
      cfg_write(CFG_ROWS_M, raw[0]);
      cfg_write(CFG_COLS_N, raw[1]);
      cfg_write(CFG_INNER_K, raw[2]);
      if ($urandom_range(0, 7) == 0) cfg_write(CFG_SPARE, SIZE_W'($urandom));
      cfg_chan.valid <= 1'b0;
      m = eff_dim(rows_reg);
      n = eff_dim(cols_reg);
      k = eff_dim(inner_reg);

      // load whatever a run over the new sizes would touch unwritten
      it = '0;
      for (i = 0; i < m; i++)
        for (j = 0; j < k; j++)
          if (!a_set[i*DIM+j]) begin
            it.kind = KIND_WRITE_A; it.row = POS_W'(i); it.col = POS_W'(j);
            it.elem_value = rand_elem(); it.acc_value = rand_acc();
            send_op(it, 1'b0, '0);
            items_sent++;
          end
      for (i = 0; i < k; i++)
        for (j = 0; j < n; j++)
          if (!b_set[i*DIM+j]) begin
            it.kind = KIND_WRITE_B; it.row = POS_W'(i); it.col = POS_W'(j);
            it.elem_value = rand_elem(); it.acc_value = rand_acc();
            send_op(it, 1'b0, '0);
            items_sent++;
          end
      for (i = 0; i < m; i++)
        for (j = 0; j < n; j++)
          if (!c_set[i*DIM+j]) begin
            it.kind = KIND_WRITE_C; it.row = POS_W'(i); it.col = POS_W'(j);
            it.elem_value = rand_elem(); it.acc_value = rand_acc();
            send_op(it, 1'b0, '0);
            items_sent++;
          end

      body_len = $urandom_range(10, 30);
      for (i = 0; i < body_len; i++) begin
        r = $urandom_range(0, 99);
        it.elem_value = rand_elem();
        it.acc_value  = rand_acc();
        it.row        = POS_W'($urandom_range(0, DIM - 1));
        it.col        = POS_W'($urandom_range(0, DIM - 1));
        if (r < 20) begin
          it.kind = KIND_WRITE_A; it.row = pick_pos(m); it.col = pick_pos(k);
        end else if (r < 38) begin
          it.kind = KIND_WRITE_B; it.row = pick_pos(k); it.col = pick_pos(n);
        end else if (r < 52) begin
          it.kind = KIND_WRITE_C; it.row = pick_pos(m); it.col = pick_pos(n);
        end else if (r < 72) begin
          it.kind = KIND_READ_C; it.row = pick_pos(m); it.col = pick_pos(n);
        end else if (r < 92) begin
          it.kind = KIND_RUN;
        end else begin
          it.kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        end
        send_op(it, 1'b0, '0);
        if (it.kind <= KIND_READ_C) items_sent++;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("matrix_multiply_accumulate verification clean");
    else
      $display("matrix_multiply_accumulate verification failed");
    $finish;
  end

endmodule

// File: matrix_multiply_accumulate.f
+incdir+sv
sv/mma_pkg.sv
sv/mma_chan_if.sv
sv/matrix_multiply_accumulate.sv
test/matrix_multiply_accumulate_tb.sv
